FILE: sv/les_pkg.sv
// Shared types and constants for the Lorenz Euler step core.
// Used by les_ctrl, les_dpath and lorenz_euler_step_core; no dependencies.
`default_nettype none

package les_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 20;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int DT_W      = 16;
  localparam int SCALE_W   = 21;
  localparam int IDX_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA,
    REG_BETA,
    REG_RHO,
    REG_TIME_STEP,
    REG_OUTPUT_SCALE,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_DX,
    OP_MY,
    OP_XY,
    OP_BZ,
    OP_PX,
    OP_PY,
    OP_PZ,
    OP_EX,
    OP_EY,
    OP_EZ
  } op_t;

  typedef struct packed {
    logic start;
    logic prep;
    logic issue;
    op_t  op;
    logic publish;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/lorenz_euler_step_core.sv
// Top level of the Lorenz Euler step core: controller plus datapath.
// Depends on les_pkg, les_ctrl and les_dpath.
//
// Each accepted item advances the Lorenz point by one saturating Q12.20 Euler
// step and yields one result: the new point times output_scale, the step index
// and a clip flag. restart reloads start_x/y/z and zeroes the index first.
// Ten products go in turn through one shared 32x32 multiplier, one per cycle.
// in_stall stays high until the result is published, so no new item is taken
// before the last one is done. A finished result waits in the output register
// while the next item is accepted.
// Write configuration only while the block is idle; cfg_ready is always high.
`default_nettype none

module lorenz_euler_step_core
  import les_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [CFG_IDX_W-1:0]       cfg_index,
  input  wire  [CFG_DAT_W-1:0]       cfg_data,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        in_restart,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [COORD_W-1:0]  out_x_out,
  output logic signed [COORD_W-1:0]  out_y_out,
  output logic signed [COORD_W-1:0]  out_z_out,
  output logic        [IDX_W-1:0]    out_step_index,
  output logic                       out_saturated
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  les_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  les_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .in_restart     (in_restart),
    .out_x_out      (out_x_out),
    .out_y_out      (out_y_out),
    .out_z_out      (out_z_out),
    .out_step_index (out_step_index),
    .out_saturated  (out_saturated)
  );

endmodule

`default_nettype wire

FILE: sv/les_ctrl.sv
// Controller for the Lorenz Euler step core: item handshake, op sequencing, result valid.
// Depends on les_pkg.
`default_nettype none

module les_ctrl
  import les_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd         = '0;
    cmd.op      = op_r;
    cmd.start   = accept;
    cmd.prep    = (state_r == ST_PREP);
    cmd.issue   = (state_r == ST_RUN);
    cmd.publish = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_DX;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          op_r    <= OP_DX;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (op_r == OP_EZ) begin
            state_r <= ST_DRAIN;
          end else begin
            op_r <= op_t'(op_r + 4'd1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/les_dpath.sv
// Datapath for the Lorenz Euler step core: config registers, point state,
// one shared multiplier with saturating retire stage, output registers. Depends on les_pkg.
`default_nettype none

module les_dpath
  import les_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [CFG_IDX_W-1:0]        cfg_index,
  input  wire  [CFG_DAT_W-1:0]        cfg_data,
  input  cmd_t                        cmd,
  input  wire                         in_restart,
  output logic signed [COORD_W-1:0]   out_x_out,
  output logic signed [COORD_W-1:0]   out_y_out,
  output logic signed [COORD_W-1:0]   out_z_out,
  output logic        [IDX_W-1:0]     out_step_index,
  output logic                        out_saturated
);

  localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam coord_t SIGMA_RST = 32'sd10485760;
  localparam coord_t BETA_RST  = 32'sd2796132;
  localparam coord_t RHO_RST   = 32'sd29360128;
  localparam coord_t START_RST = 32'sd1048576;
  localparam logic [DT_W-1:0]    DT_RST    = 16'd1049;
  localparam logic [SCALE_W-1:0] SCALE_RST = 21'd31457;

  typedef struct packed {
    logic   clip;
    coord_t val;
  } res_t;

  function automatic res_t sat_addsub(input coord_t a, input coord_t b, input logic sub);
    logic signed [COORD_W:0] s;
    res_t r;
    s = sub ? ({a[COORD_W-1], a} - {b[COORD_W-1], b})
            : ({a[COORD_W-1], a} + {b[COORD_W-1], b});
    r.clip = (s[COORD_W] != s[COORD_W-1]);
    r.val  = r.clip ? (s[COORD_W] ? CMIN : CMAX) : s[COORD_W-1:0];
    return r;
  endfunction

  function automatic res_t sat_prod(input prod_t p);
    prod_t sh;
    res_t r;
    sh     = p >>> FRAC_BITS;
    r.clip = (sh[PROD_W-1:COORD_W-1] != {(PROD_W-COORD_W+1){sh[COORD_W-1]}});
    r.val  = r.clip ? (p[PROD_W-1] ? CMIN : CMAX) : sh[COORD_W-1:0];
    return r;
  endfunction

  coord_t sigma_r, beta_r, rho_r, start_x_r, start_y_r, start_z_r;
  logic [DT_W-1:0]    dt_r;
  logic [SCALE_W-1:0] scale_r;

  coord_t x_r, y_r, z_r;
  coord_t d1_r, d2_r, dx_r, dy_r, dz_r, t_r;
  coord_t ex_r, ey_r, ez_r;
  logic [IDX_W-1:0] cnt_r;
  logic   flag_r;

  prod_t  prod_r;
  prod_t  prod_nxt;
  logic   ret_vld_r;
  op_t    ret_op_r;

  coord_t mul_a, mul_b;
  res_t   pres;
  coord_t add_a, add_b;
  logic   add_sub, add_use;
  res_t   ares;
  res_t   prep_d1, prep_d2;

  always_comb begin
    mul_a = sigma_r;
    mul_b = d1_r;
    case (cmd.op)
      OP_DX: begin mul_a = sigma_r; mul_b = d1_r; end
      OP_MY: begin mul_a = x_r; mul_b = d2_r; end
      OP_XY: begin mul_a = x_r; mul_b = y_r; end
      OP_BZ: begin mul_a = beta_r; mul_b = z_r; end
      OP_PX: begin mul_a = coord_t'({{(COORD_W-DT_W){1'b0}}, dt_r}); mul_b = dx_r; end
      OP_PY: begin mul_a = coord_t'({{(COORD_W-DT_W){1'b0}}, dt_r}); mul_b = dy_r; end
      OP_PZ: begin mul_a = coord_t'({{(COORD_W-DT_W){1'b0}}, dt_r}); mul_b = dz_r; end
      OP_EX: begin mul_a = x_r; mul_b = coord_t'({{(COORD_W-SCALE_W){1'b0}}, scale_r}); end
      OP_EY: begin mul_a = y_r; mul_b = coord_t'({{(COORD_W-SCALE_W){1'b0}}, scale_r}); end
      OP_EZ: begin mul_a = z_r; mul_b = coord_t'({{(COORD_W-SCALE_W){1'b0}}, scale_r}); end
      default: begin mul_a = sigma_r; mul_b = d1_r; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign pres    = sat_prod(prod_r);
  assign prep_d1 = sat_addsub(y_r, x_r, 1'b1);
  assign prep_d2 = sat_addsub(rho_r, z_r, 1'b1);

  always_comb begin
    add_a   = pres.val;
    add_b   = y_r;
    add_sub = 1'b1;
    add_use = 1'b0;
    case (ret_op_r)
      OP_MY: begin add_a = pres.val; add_b = y_r; add_sub = 1'b1; add_use = 1'b1; end
      OP_BZ: begin add_a = t_r; add_b = pres.val; add_sub = 1'b1; add_use = 1'b1; end
      OP_PX: begin add_a = x_r; add_b = pres.val; add_sub = 1'b0; add_use = 1'b1; end
      OP_PY: begin add_a = y_r; add_b = pres.val; add_sub = 1'b0; add_use = 1'b1; end
      OP_PZ: begin add_a = z_r; add_b = pres.val; add_sub = 1'b0; add_use = 1'b1; end
      default: begin add_use = 1'b0; end
    endcase
    ares = sat_addsub(add_a, add_b, add_sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r   <= SIGMA_RST;
      beta_r    <= BETA_RST;
      rho_r     <= RHO_RST;
      dt_r      <= DT_RST;
      scale_r   <= SCALE_RST;
      start_x_r <= START_RST;
      start_y_r <= START_RST;
      start_z_r <= START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGMA:        sigma_r   <= coord_t'(cfg_data);
        REG_BETA:         beta_r    <= coord_t'(cfg_data);
        REG_RHO:          rho_r     <= coord_t'(cfg_data);
        REG_TIME_STEP:    dt_r      <= cfg_data[DT_W-1:0];
        REG_OUTPUT_SCALE: scale_r   <= cfg_data[SCALE_W-1:0];
        REG_START_X:      start_x_r <= coord_t'(cfg_data);
        REG_START_Y:      start_y_r <= coord_t'(cfg_data);
        REG_START_Z:      start_z_r <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= START_RST;
      y_r       <= START_RST;
      z_r       <= START_RST;
      cnt_r     <= '0;
      flag_r    <= 1'b0;
      ret_vld_r <= 1'b0;
      ret_op_r  <= OP_DX;
    end else begin
      ret_vld_r <= cmd.issue;
      ret_op_r  <= cmd.op;
      if (cmd.start && in_restart) begin
        x_r   <= start_x_r;
        y_r   <= start_y_r;
        z_r   <= start_z_r;
        cnt_r <= '0;
      end
      if (cmd.prep) begin
        d1_r   <= prep_d1.val;
        d2_r   <= prep_d2.val;
        flag_r <= prep_d1.clip | prep_d2.clip;
      end
      if (ret_vld_r) begin
        flag_r <= flag_r | pres.clip | (add_use & ares.clip);
        case (ret_op_r)
          OP_DX: dx_r <= pres.val;
          OP_MY: dy_r <= ares.val;
          OP_XY: t_r  <= pres.val;
          OP_BZ: dz_r <= ares.val;
          OP_PX: x_r  <= ares.val;
          OP_PY: y_r  <= ares.val;
          OP_PZ: z_r  <= ares.val;
          OP_EX: ex_r <= pres.val;
          OP_EY: ey_r <= pres.val;
          OP_EZ: ez_r <= pres.val;
          default: ;
        endcase
      end
      if (cmd.publish) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r <= prod_nxt;
    end
    if (cmd.publish) begin
      out_x_out      <= ex_r;
      out_y_out      <= ey_r;
      out_z_out      <= ez_r;
      out_step_index <= cnt_r;
      out_saturated  <= flag_r;
    end
  end

endmodule

`default_nettype wire
